>>> sv/lpdr_pkg.sv
// Shared types and constants for the lidar point decimate / range-ring binner.
// Used by lpdr_front, lpdr_ring_cell and lidar_point_decimate_range_ring_bin.
// No dependencies.
package lpdr_pkg;

  // Ring chain length and field widths
  localparam int NUM_RINGS = 10;
  localparam int COORD_W   = 19;   // signed mm coordinates and height limits
  localparam int RADIUS_W  = 18;   // radius limits, mm
  localparam int RSQ_W     = 2 * RADIUS_W;
  localparam int SQ_W      = 37;   // one squared coordinate, below 2^37
  localparam int D2_W      = 38;   // sum of three squares
  localparam int WID_W     = 6;    // one ring width, metres
  localparam int RINGS_W   = 60;   // packed ring widths register
  localparam int BND_W     = 20;   // ring boundary in mm, below 2^20
  localparam int BSQ_W     = 2 * BND_W;
  localparam int IDX_W     = 4;
  localparam int KEEP_W    = 8;
  localparam int MM_PER_M  = 1000;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RINGS_W;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_EVERY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RING_WIDTHS = 3'd5;

  // Register reset values
  localparam logic [KEEP_W-1:0]          RST_KEEP_EVERY  = 8'd3;
  localparam logic signed [COORD_W-1:0]  RST_HEIGHT_MIN  = -19'sd800;
  localparam logic signed [COORD_W-1:0]  RST_HEIGHT_MAX  = 19'sd2000;
  localparam logic [RADIUS_W-1:0]        RST_RANGE_MIN   = 18'd0;
  localparam logic [RADIUS_W-1:0]        RST_RANGE_MAX   = 18'd30000;
  localparam logic [RINGS_W-1:0]         RST_RING_WIDTHS = 60'd54896625982386370;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [KEEP_W-1:0]         keep_every;
    logic signed [COORD_W-1:0] height_min;
    logic signed [COORD_W-1:0] height_max;
    logic [RADIUS_W-1:0]       range_min;
    logic [RADIUS_W-1:0]       range_max;
    logic [RINGS_W-1:0]        ring_widths;
  } cfg_t;

  // One point moving down the ring chain
  typedef struct packed {
    logic              valid;
    logic              filtered;  // kept and inside the height window
    logic              active;    // filtered and inside the radius limits
    logic              found;     // some earlier cell matched
    logic [IDX_W-1:0]  idx;       // matching ring, 0 until found
    logic [D2_W-1:0]   d2;
    logic [BND_W-1:0]  lower;     // lower boundary of the next ring, mm
    logic [BSQ_W-1:0]  lower_sq;
  } tok_t;

endpackage

>>> sv/lpdr_front.sv
// Front end: decimation counter, height window, squared range and radius limits.
// Produces the token that enters the first ring cell.
// Depends on lpdr_pkg.
module lpdr_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,       // whole pipeline moves
  input  logic                                 accept,    // input transfer this cycle
  input  logic                                 frame_start,
  input  logic signed [lpdr_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [lpdr_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [lpdr_pkg::COORD_W-1:0]  pos_z,
  input  lpdr_pkg::cfg_t                       cfg,
  output lpdr_pkg::tok_t                       tok_out
);

  // Decimation counter
  logic [lpdr_pkg::KEEP_W-1:0] dec_count;
  logic [lpdr_pkg::KEEP_W-1:0] dec_count_next;
  logic [lpdr_pkg::KEEP_W-1:0] period;
  logic [lpdr_pkg::KEEP_W-1:0] cnt_cur;
  logic [lpdr_pkg::KEEP_W:0]   cnt_inc;
  logic                        kept;
  logic                        height_ok;

  always_comb begin
    period         = (cfg.keep_every == '0) ? lpdr_pkg::KEEP_W'(1) : cfg.keep_every;
    cnt_cur        = frame_start ? '0 : dec_count;
    kept           = (cnt_cur == '0);
    cnt_inc        = {1'b0, cnt_cur} + (lpdr_pkg::KEEP_W+1)'(1);
    dec_count_next = (cnt_inc >= {1'b0, period}) ? '0 : cnt_inc[lpdr_pkg::KEEP_W-1:0];
    height_ok      = (pos_z >= cfg.height_min) && (pos_z <= cfg.height_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_count <= '0;
    end else if (accept) begin
      dec_count <= dec_count_next;
    end
  end

  // Stage 1: squares
  logic signed [2*lpdr_pkg::COORD_W-1:0] px, py, pz;
  assign px = pos_x * pos_x;
  assign py = pos_y * pos_y;
  assign pz = pos_z * pos_z;

  logic                      v1, filt1;
  logic [lpdr_pkg::SQ_W-1:0] sqx, sqy, sqz;

  // Stage 2: sum
  logic                      v2, filt2;
  logic [lpdr_pkg::D2_W-1:0] d2_2;

  // Stage 3: radius limits
  logic                      v3, filt3, act3;
  logic [lpdr_pkg::D2_W-1:0] d2_3;

  // Squared radius limits follow the registers
  logic [lpdr_pkg::RSQ_W-1:0] rmin_sq, rmax_sq;

  always_ff @(posedge clk) begin
    rmin_sq <= lpdr_pkg::RSQ_W'(cfg.range_min) * lpdr_pkg::RSQ_W'(cfg.range_min);
    rmax_sq <= lpdr_pkg::RSQ_W'(cfg.range_max) * lpdr_pkg::RSQ_W'(cfg.range_max);
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      filt1 <= kept && height_ok;
      sqx   <= px[lpdr_pkg::SQ_W-1:0];
      sqy   <= py[lpdr_pkg::SQ_W-1:0];
      sqz   <= pz[lpdr_pkg::SQ_W-1:0];
      filt2 <= filt1;
      d2_2  <= lpdr_pkg::D2_W'(sqx) + lpdr_pkg::D2_W'(sqy) + lpdr_pkg::D2_W'(sqz);
      filt3 <= filt2;
      d2_3  <= d2_2;
      act3  <= filt2 && (d2_2 > lpdr_pkg::D2_W'(rmin_sq))
                     && (d2_2 < lpdr_pkg::D2_W'(rmax_sq));
    end
  end

  always_comb begin
    tok_out          = '0;
    tok_out.valid    = v3;
    tok_out.filtered = filt3;
    tok_out.active   = act3;
    tok_out.d2       = d2_3;
  end

endmodule

>>> sv/lpdr_ring_cell.sv
// One ring cell: builds its upper boundary from the incoming lower one and
// tests the point against it, then hands the token to the next cell.
// Depends on lpdr_pkg.
module lpdr_ring_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic [lpdr_pkg::IDX_W-1:0]      cell_id,
  input  logic [lpdr_pkg::WID_W-1:0]      width_m,
  input  lpdr_pkg::tok_t                  tok_in,
  output lpdr_pkg::tok_t                  tok_out
);

  logic [lpdr_pkg::BND_W-1:0] upper;
  logic [lpdr_pkg::BSQ_W-1:0] upper_sq;
  logic [lpdr_pkg::BSQ_W-1:0] d2_ext;
  logic                       hit;

  // Boundary in mm, squared, then the ring test
  always_comb begin
    upper    = tok_in.lower
             + lpdr_pkg::BND_W'(width_m) * lpdr_pkg::BND_W'(lpdr_pkg::MM_PER_M);
    upper_sq = lpdr_pkg::BSQ_W'(upper) * lpdr_pkg::BSQ_W'(upper);
    d2_ext   = lpdr_pkg::BSQ_W'(tok_in.d2);
    hit      = tok_in.active && !tok_in.found
             && (d2_ext > tok_in.lower_sq) && (d2_ext <= upper_sq);
  end

  // Token register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out.valid    <= tok_in.valid;
      tok_out.filtered <= tok_in.filtered;
      tok_out.active   <= tok_in.active;
      tok_out.found    <= tok_in.found || hit;
      tok_out.idx      <= hit ? cell_id : tok_in.idx;
      tok_out.d2       <= tok_in.d2;
      tok_out.lower    <= upper;
      tok_out.lower_sq <= upper_sq;
    end
  end

endmodule

>>> sv/lidar_point_decimate_range_ring_bin.sv
// Lidar point decimation, height window and range-ring binning: top level.
// Holds the configuration registers, the front end and the chain of ring cells.
// Depends on lpdr_pkg, lpdr_front and lpdr_ring_cell.
//
// One point is taken per cycle and one result comes out per point, in order.
// A point passes 3 + NUM_RINGS register stages (13 with ten rings): three front
// stages (decimation and height window with the squares, the sum, the radius
// limits) and one stage for each ring cell; the last cell's token register is the
// output register, from which a result leaves when it is taken.
// All stages advance together whenever the output register is empty or
// being taken, so back-pressure on the output stalls the input. Configuration
// writes are always ready; make them only while no point is in flight, and they
// apply to points accepted after them.
// Ring bounds are built cell by cell as running sums of the widths times 1000 mm.
module lidar_point_decimate_range_ring_bin (
  input  logic                                clk,
  input  logic                                rst,
  // input points
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [63:0]                         s_tdata,  // pos_x[18:0], pos_y[37:19],
                                                        // pos_z[56:38], zeros
  input  logic                                s_tuser,  // frame_start
  // results
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,  // in_filtered[0], in_ring[1],
                                                        // ring_index[5:2], zeros
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lpdr_pkg::cfg_t cfg;
  logic           adv;
  logic           accept;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keep_every  <= lpdr_pkg::RST_KEEP_EVERY;
      cfg.height_min  <= lpdr_pkg::RST_HEIGHT_MIN;
      cfg.height_max  <= lpdr_pkg::RST_HEIGHT_MAX;
      cfg.range_min   <= lpdr_pkg::RST_RANGE_MIN;
      cfg.range_max   <= lpdr_pkg::RST_RANGE_MAX;
      cfg.ring_widths <= lpdr_pkg::RST_RING_WIDTHS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpdr_pkg::REG_KEEP_EVERY:  cfg.keep_every  <= cfg_data[lpdr_pkg::KEEP_W-1:0];
        lpdr_pkg::REG_HEIGHT_MIN:  cfg.height_min  <= cfg_data[lpdr_pkg::COORD_W-1:0];
        lpdr_pkg::REG_HEIGHT_MAX:  cfg.height_max  <= cfg_data[lpdr_pkg::COORD_W-1:0];
        lpdr_pkg::REG_RANGE_MIN:   cfg.range_min   <= cfg_data[lpdr_pkg::RADIUS_W-1:0];
        lpdr_pkg::REG_RANGE_MAX:   cfg.range_max   <= cfg_data[lpdr_pkg::RADIUS_W-1:0];
        lpdr_pkg::REG_RING_WIDTHS: cfg.ring_widths <= cfg_data[lpdr_pkg::RINGS_W-1:0];
        default: ;
      endcase
    end
  end

  // Token chain: front end, then one cell per ring; last token is the output register
  lpdr_pkg::tok_t tok [lpdr_pkg::NUM_RINGS+1];

  assign adv      = !tok[lpdr_pkg::NUM_RINGS].valid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  lpdr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .accept      (accept),
    .frame_start (s_tuser),
    .pos_x       (s_tdata[18:0]),
    .pos_y       (s_tdata[37:19]),
    .pos_z       (s_tdata[56:38]),
    .cfg         (cfg),
    .tok_out     (tok[0])
  );

  for (genvar k = 0; k < lpdr_pkg::NUM_RINGS; k++) begin : g_ring
    lpdr_ring_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .cell_id (lpdr_pkg::IDX_W'(k)),
      .width_m (cfg.ring_widths[lpdr_pkg::WID_W*k +: lpdr_pkg::WID_W]),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  // Result packing
  assign m_tvalid = tok[lpdr_pkg::NUM_RINGS].valid;
  assign m_tdata  = {2'b00,
                     tok[lpdr_pkg::NUM_RINGS].idx,
                     tok[lpdr_pkg::NUM_RINGS].found,
                     tok[lpdr_pkg::NUM_RINGS].filtered};

  // Checks
  a_ring_needs_filter: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("ring hit on a point that was not filtered");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[5:2] <= lpdr_pkg::IDX_W'(lpdr_pkg::NUM_RINGS - 1))
    else $error("ring index beyond last ring");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[5:2] == '0)
    else $error("nonzero ring index without a ring hit");

  a_active_filtered: assert property (@(posedge clk) disable iff (rst)
    tok[0].valid && tok[0].active |-> tok[0].filtered)
    else $error("radius test passed on an unfiltered point");

endmodule
